// ----- src/lkvc_pkg.sv -----
// Shared constants and controller/datapath handshake types for the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

    // Configuration register file.
    localparam int CAP_BITS   = 5;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    localparam logic [PADDR_BITS-3:0] CFG_IDX_CAPACITY = 1'b0;

    // Request operation codes.
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the request and clear the scan trackers
        logic scan;     // step the slot scan by one
        logic commit;   // apply the update and load the result register
    } lkvc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // last slot is being examined this cycle
        logic out_free;    // result register can take a new result
    } lkvc_status_t;

endpackage

`default_nettype wire

// ----- src/lkvc_req_if.sv -----
// Request channel interface: valid/ready handshake with operation, key and value.
`default_nettype none

interface lkvc_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [KEY_BITS-1:0]   lookup_key;
    logic signed [VALUE_BITS-1:0] write_value;

    modport source (output valid, output func, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input func, input lookup_key, input write_value,
                    output ready);
endinterface

`default_nettype wire

// ----- src/lkvc_rsp_if.sv -----
// Response channel interface: valid/ready handshake with hit flag, read value and eviction flag.
`default_nettype none

interface lkvc_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
    logic                         evicted;

    modport source (output valid, output hit, output read_value, output evicted,
                    input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    output ready);
endinterface

`default_nettype wire

// ----- src/lkvc_ctrl.sv -----
// Controller state machine: sequences accept, slot scan and commit of one request.
`default_nettype none

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire lkvc_status_t status,
    output lkvc_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // Hold the update until the result register has room.
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready  = (state_reg == ST_IDLE);
    assign cmd.accept = (state_reg == ST_IDLE) && req_valid;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.commit = (state_reg == ST_UPDATE) && status.out_free;

endmodule

`default_nettype wire

// ----- src/lkvc_dpath.sv -----
// Datapath: key/value memories, valid and recency state, scan trackers and result register.
`default_nettype none

module lkvc_dpath
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lkvc_cmd_t                    cmd,
    output lkvc_status_t                      status,
    input  wire logic                         func,
    input  wire logic signed [KEY_BITS-1:0]   lookup_key,
    input  wire logic signed [VALUE_BITS-1:0] write_value,
    input  wire logic [CAP_BITS-1:0]          capacity,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              hit,
    output logic signed [VALUE_BITS-1:0]      read_value,
    output logic                              evicted
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

    // Latched request.
    logic                  func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] wval_reg;

    // Storage.
    logic [KEY_BITS-1:0]   key_mem [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]      rank_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]      rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]      count_reg, count_next;

    // Scan pipeline.
    logic [CNT_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      scan_addr;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg;

    // Scan trackers.
    logic                  hit_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [IDX_W-1:0]      hit_rank_reg;
    logic [VALUE_BITS-1:0] hit_value_reg;
    logic                  have_free_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [IDX_W-1:0]      victim_idx_reg;

    // Result register.
    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_evicted_reg;

    // Update decisions.
    logic [CAP_W-1:0]      cap_ext;
    logic [CAP_W-1:0]      max_ext;
    logic [CAP_W-1:0]      eff_cap;
    logic                  need_evict;
    logic                  is_put;
    logic                  do_evict;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W-1:0]      wr_addr;
    logic                  mem_we;
    logic                  eval_valid;
    logic                  eval_match;
    logic [VALUE_BITS-1:0] result_value;

    assign is_put = (func_reg == FUNC_PUT);

    // Capacity zero acts as one; anything above the store depth saturates.
    assign cap_ext = CAP_W'(capacity);
    assign max_ext = CAP_W'(MAX_ENTRIES);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (cap_ext > max_ext)
        begin
            eff_cap = max_ext;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign need_evict = (CAP_W'(count_reg) >= eff_cap);
    assign do_evict   = is_put && !hit_found_reg && need_evict;

    // New entries take the lowest free slot, counting the slot just evicted.
    always_comb
    begin
        if (do_evict)
        begin
            if (have_free_reg && (free_idx_reg < victim_idx_reg))
            begin
                slot = free_idx_reg;
            end
            else
            begin
                slot = victim_idx_reg;
            end
        end
        else
        begin
            slot = free_idx_reg;
        end
    end

    assign wr_addr = hit_found_reg ? hit_idx_reg : slot;
    assign mem_we  = cmd.commit && is_put;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg <= func;
            key_reg  <= lookup_key;
            wval_reg <= write_value;
        end
    end

    // Key and value memories: one write port, one registered read port.
    assign scan_addr = (cnt_reg < CNT_W'(MAX_ENTRIES)) ? cnt_reg[IDX_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_addr] <= key_reg;
            val_mem[wr_addr] <= wval_reg;
        end
        rd_key_reg <= key_mem[scan_addr];
        rd_val_reg <= val_mem[scan_addr];
        rd_idx_reg <= scan_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            rd_vld_reg <= cmd.scan && (cnt_reg < CNT_W'(MAX_ENTRIES));
        end
    end

    assign status.scan_done = (cnt_reg == CNT_W'(MAX_ENTRIES));
    assign status.out_free  = !out_valid_reg || out_ready;

    // Examine the slot whose contents arrived from the memories this cycle.
    assign eval_valid = rd_vld_reg && valid_reg[rd_idx_reg];
    assign eval_match = eval_valid && (rd_key_reg == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            hit_rank_reg   <= '0;
            hit_value_reg  <= '0;
            have_free_reg  <= 1'b0;
            free_idx_reg   <= '0;
            victim_idx_reg <= '0;
        end
        else if (cmd.accept)
        begin
            hit_found_reg <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else
        begin
            if (eval_match)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= rd_idx_reg;
                hit_rank_reg  <= rank_reg[rd_idx_reg];
                hit_value_reg <= rd_val_reg;
            end
            if (rd_vld_reg && !valid_reg[rd_idx_reg] && !have_free_reg)
            begin
                have_free_reg <= 1'b1;
                free_idx_reg  <= rd_idx_reg;
            end
            // Valid ranks are distinct and dense, so the oldest holds count-1.
            if (eval_valid && (CNT_W'(rank_reg[rd_idx_reg]) == count_reg - CNT_W'(1)))
            begin
                victim_idx_reg <= rd_idx_reg;
            end
        end
    end

    // Recency, valid and count update at commit.
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        if (cmd.commit)
        begin
            if (hit_found_reg)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (valid_reg[i] && (IDX_W'(i) != hit_idx_reg) &&
                        (rank_reg[i] < hit_rank_reg))
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_next[hit_idx_reg] = '0;
            end
            else if (is_put)
            begin
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    if (valid_reg[i] && !(do_evict && (IDX_W'(i) == victim_idx_reg)))
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                if (do_evict)
                begin
                    valid_next[victim_idx_reg] = 1'b0;
                end
                valid_next[slot] = 1'b1;
                rank_next[slot]  = '0;
                if (!do_evict)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    // Result register.
    always_comb
    begin
        if (is_put)
        begin
            result_value = '0;
        end
        else if (hit_found_reg)
        begin
            result_value = hit_value_reg;
        end
        else
        begin
            result_value = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg     <= hit_found_reg;
            out_value_reg   <= result_value;
            out_evicted_reg <= do_evict;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign read_value = out_value_reg;
    assign evicted    = out_evicted_reg;

    // The valid bits and the entry count must always agree.
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count disagrees with valid bits");

    // The count never exceeds the store depth.
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above store depth");

    // An eviction always removes an entry that is really present.
    a_victim_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && do_evict |-> valid_reg[victim_idx_reg])
        else $error("eviction of an empty slot");

    // A commit is never lost: the result register holds it on the next cycle.
    a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

`default_nettype wire

// ----- src/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: channel hookup, configuration port and submodules.
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement. Each request
// transfer on req carries a get (func 0) or a put (func 1) with a key and, for a put, a
// value; exactly one response transfer on rsp follows per request, in request order.
// A get that hits returns the stored value and makes the entry most recent; a get that
// misses returns all ones with hit clear. A put overwrites a present key, or inserts a
// new entry in the lowest free slot, first evicting the least recent entry when the
// entry count has reached the capacity register (zero counts as one, values above
// MAX_ENTRIES saturate). Requests are handled one at a time: after a request transfer
// the controller scans every slot through a single read port of the key and value
// memories, one slot per cycle, so a request passes through accept, a scan that ends
// when the registered read of the last slot is examined, and an update step. The
// result register decouples the response side: a new request is accepted while the
// previous response still waits, and only the update step of the next request stalls
// if that response has not yet been taken. The capacity register sits at byte address
// 0 of the APB-style port, resets to 16 and should be written only while no request is
// in flight. Key and value memories are not cleared at reset; the per-slot valid bits
// and recency ranks are.

module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    lkvc_req_if.sink                     req,
    lkvc_rsp_if.source                   rsp,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_BITS-1:0]   paddr,
    input  wire logic [PDATA_BITS-1:0]   pwdata,
    output logic      [PDATA_BITS-1:0]   prdata,
    output logic                         pready
);

    lkvc_cmd_t             cmd;
    lkvc_status_t          status;
    logic [CAP_BITS-1:0]   cap_reg;
    logic [PADDR_BITS-3:0] reg_idx;
    logic                  cfg_write;
    logic                  req_ready;
    logic                  rsp_valid;
    logic                  rsp_hit;
    logic                  rsp_evicted;
    logic signed [VALUE_BITS-1:0] rsp_value;

    // Configuration port: byte-addressed with word-sized registers, and pready is tied high so no transfer waits.
    assign reg_idx   = paddr[PADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write && (reg_idx == CFG_IDX_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_BITS-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            CFG_IDX_CAPACITY: prdata = PDATA_BITS'(cap_reg);
            default:          prdata = '0;
        endcase
    end

    // Controller: sequences each request through scan and update.
    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: storage, scan trackers and the result register.
    lkvc_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .func        (req.func),
        .lookup_key  (req.lookup_key),
        .write_value (req.write_value),
        .capacity    (cap_reg),
        .out_valid   (rsp_valid),
        .out_ready   (rsp.ready),
        .hit         (rsp_hit),
        .read_value  (rsp_value),
        .evicted     (rsp_evicted)
    );

    assign req.ready      = req_ready;
    assign rsp.valid      = rsp_valid;
    assign rsp.hit        = rsp_hit;
    assign rsp.read_value = rsp_value;
    assign rsp.evicted    = rsp_evicted;

endmodule

`default_nettype wire
